@@ sv/jch_pkg.sv @@
`default_nettype none
package jch_pkg;

	// 64-bit LCG multiplier, split in halves for the 32x32 multiplier
	localparam logic [63:0] LCG_MULT    = 64'd2862933555777941757;
	localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
	localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

	localparam int unsigned NUM_SHIFT = 31;
	localparam int unsigned KEY_SHIFT = 33;
	localparam int unsigned DIV_STEPS = 64;

	typedef logic [2:0] state_t;

endpackage
`default_nettype wire

@@ sv/jump_consistent_hash_bucket.sv @@
`default_nettype none
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    key[63:0], bucket_count[31:0]
// out      out  out_valid/out_ready  bucket[31:0], no_bucket
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Each round runs the LCG step on the shared 32x32 multiplier, then the
// bit-serial restoring divider, then compares against bucket_count.
// An item with zero buckets skips the rounds.
// The result sits in an output register, so a new item is taken while it waits.
// arst_n clears the sequencer and the output valid flag.
module jump_consistent_hash_bucket (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] key,
	input  wire logic [31:0] bucket_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      bucket,
	output logic             no_bucket
);

	localparam jch_pkg::state_t S_IDLE = 3'd0;
	localparam jch_pkg::state_t S_MUL0 = 3'd1;
	localparam jch_pkg::state_t S_MUL1 = 3'd2;
	localparam jch_pkg::state_t S_MUL2 = 3'd3;
	localparam jch_pkg::state_t S_DIV  = 3'd4;
	localparam jch_pkg::state_t S_CHK  = 3'd5;
	localparam jch_pkg::state_t S_FIN  = 3'd6;

	localparam logic [5:0] LAST_STEP = 6'(jch_pkg::DIV_STEPS - 1);

	jch_pkg::state_t state_q;
	logic [63:0] key_q;
	logic [31:0] count_q;
	logic [31:0] cand_q;
	logic        nob_q;
	logic [63:0] acc_q;
	logic [63:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] bucket_q;
	logic        no_bucket_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] key_next;
	logic [32:0] cand_p1;
	logic [32:0] rem_sh;
	logic [32:0] rem_diff;
	logic        rem_ge;
	logic        continue_round;
	logic        out_free;

	// shared multiplier: low*low, low*high, high*low
	assign mul_a = (state_q == S_MUL2) ? key_q[63:32] : key_q[31:0];
	assign mul_b = (state_q == S_MUL1) ? jch_pkg::LCG_MULT_HI : jch_pkg::LCG_MULT_LO;
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	assign key_next = acc_q + {prod[31:0], 32'd0} + 64'd1;
	assign cand_p1  = {1'b0, cand_q} + 33'd1;

	assign rem_sh   = {rem_q, num_q[63]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_ge   = (rem_sh >= {1'b0, div_q});

	assign continue_round = (num_q[63:32] == 32'd0) && (num_q[31:0] < count_q);
	assign out_free       = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign bucket    = bucket_q;
	assign no_bucket = no_bucket_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (bucket_count == 32'd0) ? S_FIN : S_MUL0;
					end
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == LAST_STEP)
						state_q <= S_CHK;
				end
				S_CHK: state_q <= continue_round ? S_MUL0 : S_FIN;
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q   <= key;
				count_q <= bucket_count;
				cand_q  <= (bucket_count == 32'd0) ? '1 : 32'd0;
				nob_q   <= (bucket_count == 32'd0);
			end
			S_MUL0: acc_q <= prod;
			S_MUL1: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			S_MUL2: begin
				key_q <= key_next;
				div_q <= {1'b0, key_next[63:jch_pkg::KEY_SHIFT]} + 32'd1;
				num_q <= {cand_p1, 31'd0};
				rem_q <= 32'd0;
				cnt_q <= 6'd0;
			end
			S_DIV: begin
				// shift in one numerator bit, subtract when it fits
				rem_q <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
				num_q <= {num_q[62:0], rem_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			S_CHK: begin
				if (continue_round)
					cand_q <= num_q[31:0];
			end
			S_FIN: begin
				if (out_free) begin
					bucket_q    <= cand_q;
					no_bucket_q <= nob_q;
				end
			end
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_FIN || state_q == S_MUL0))
		else $error("accepted item did not start the sequencer");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != 32'd0 && div_q <= 32'h8000_0000))
		else $error("divisor out of range");

	a_target_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && continue_round) |-> (num_q[31:0] > cand_q))
		else $error("jump target did not increase");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("finished item not placed in output register");

	a_nob_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_bucket) |-> (bucket == 32'hFFFF_FFFF))
		else $error("no_bucket result must be all ones");

endmodule
`default_nettype wire

@@ bench/jump_consistent_hash_bucket_test.sv @@
`default_nettype none
module jump_consistent_hash_bucket_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] MIX_MULT   = 64'd2862933555777941757;
	localparam int          TARGET_SHL = 31;
	localparam int          KEY_SHR    = 33;
	localparam int          HOLD_LEN   = 2000;
	localparam int          N_RANDOM   = 1136;

	typedef struct packed {
		logic [31:0] bucket;
		logic        no_bucket;
	} bucket_pick_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] key;
	logic [31:0] bucket_count;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] bucket;
	logic        no_bucket;

	bucket_pick_t pending_picks[$];
	int           mismatches = 0;
	bit           steady = 1'b0;
	bit           hold_request = 1'b0;

	jump_consistent_hash_bucket u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key          (key),
		.bucket_count (bucket_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket       (bucket),
		.no_bucket    (no_bucket)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Jump hash with an exact integer quotient; the target strictly grows each round.
	function automatic bucket_pick_t jump_bucket_of(input logic [63:0] k_in,
		input logic [31:0] count);
		logic [63:0]  k;
		logic [63:0]  cand;
		logic [63:0]  target;
		logic [63:0]  divisor;
		bucket_pick_t p;
		k = k_in;
		cand = 64'd0;
		target = 64'd0;
		if (count == 32'd0) begin
			p.bucket = '1;
			p.no_bucket = 1'b1;
			return p;
		end
		while (target < {32'd0, count}) begin
			cand = target;
			k = k * MIX_MULT + 64'd1;
			divisor = (k >> KEY_SHR) + 64'd1;
			target = ((cand + 64'd1) << TARGET_SHL) / divisor;
		end
		p.bucket = cand[31:0];
		p.no_bucket = 1'b0;
		return p;
	endfunction

	// Mostly small counts keep the run short; a few span all 32 bits.
	function automatic logic [31:0] random_count();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 32'd0;
		else if (r < 60)
			return $urandom_range(16, 1);
		else if (r < 85)
			return $urandom_range(1024, 17);
		else if (r < 97)
			return $urandom_range(32'h0010_0000, 1025);
		else
			return $urandom;
	endfunction

	function automatic logic [63:0] random_key();
		int r;
		r = $urandom_range(49);
		if (r == 0)
			return 64'd0;
		else if (r == 1)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	task automatic send_item(input logic [63:0] k, input logic [31:0] count);
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		bucket_count <= count;
		do
			@(posedge clk);
		while (!in_ready);
		pending_picks.push_back(jump_bucket_of(k, count));
	endtask

	task automatic test_directed();
		send_item(64'd0, 32'd0);
		send_item('1, 32'd0);
		send_item(64'h0123_4567_89ab_cdef, 32'd0);
		send_item(64'd0, 32'd1);
		send_item('1, 32'd1);
		send_item(64'd0, 32'd2);
		send_item('1, 32'd2);
		send_item(64'h8000_0000_0000_0000, 32'd3);
		send_item(64'd1, 32'd1000);
		send_item(64'd0, 32'hffff_ffff);
		send_item('1, 32'hffff_ffff);
		send_item(64'h8000_0000_0000_0000, 32'h8000_0000);
		send_item(64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
		send_item(64'h5555_5555_aaaa_aaaa, 32'haaaa_aaaa);
		send_item(64'haaaa_aaaa_5555_5555, 32'h5555_5555);
	endtask

	// Receiver stalls for a long stretch while items keep coming.
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (16)
			send_item(random_key(), $urandom_range(64, 0));
	endtask

	task automatic test_random();
		for (int i = 0; i < N_RANDOM; i++) begin
			steady = (i >= 400 && i < 600);
			send_item(random_key(), random_count());
		end
		steady = 1'b0;
	endtask

	// Result checker and receiver-side ready
	initial begin
		int           hold_left;
		bucket_pick_t want;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_picks.size() == 0) begin
					$display("%0t unexpected result: bucket=%h no_bucket=%b",
						$time, bucket, no_bucket);
					mismatches++;
				end else begin
					want = pending_picks.pop_front();
					if (bucket !== want.bucket) begin
						$display("%0t bucket mismatch: expected %h actual %h",
							$time, want.bucket, bucket);
						mismatches++;
					end
					if (no_bucket !== want.no_bucket) begin
						$display("%0t no_bucket mismatch: expected %b actual %b",
							$time, want.no_bucket, no_bucket);
						mismatches++;
					end
				end
			end
			if (hold_request) begin
				hold_left = HOLD_LEN;
				hold_request = 1'b0;
			end
			if (arst_n !== 1'b1) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		key = 64'd0;
		bucket_count = 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray result
		waited = 0;
		while (pending_picks.size() != 0 && waited < 200_000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_picks.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_picks.size());
			mismatches++;
		end
		repeat (200) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
sv/jch_pkg.sv
sv/jump_consistent_hash_bucket.sv
bench/jump_consistent_hash_bucket_test.sv
